// ===== hw/rtl/utf8dec_pkg.sv =====
// Shared constants, types and the lead-byte length function for the UTF-8 decoder.
package utf8dec_pkg;

    // Longest sequence accepted; longer leads pass through as single bytes (4..6)
    localparam int MAX_SEQ_BYTES = 6;
    // Continuation bytes kept for a raw flush
    localparam int HELD_DEPTH    = 4;
    // Most results one input byte can cause
    localparam int RUN_DEPTH     = 6;
    localparam int CP_WIDTH      = 31;

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [7:0] LEAD_BITS = 8'h7F;

    typedef logic [7:0]          byte_t;
    typedef logic [CP_WIDTH-1:0] cp_t;
    typedef logic [2:0]          len_t;

    // One queued result
    typedef struct packed {
        cp_t  cp;
        logic raw;
    } result_t;

    // Sequence length implied by a lead byte; 1 for anything that is not a lead
    function automatic len_t seq_length(input byte_t b);
        len_t len;
        if (b < 8'hC2)
            len = 3'd1;
        else if (b < 8'hE0)
            len = 3'd2;
        else if (b < 8'hF0)
            len = 3'd3;
        else if (b < 8'hF8)
            len = 3'd4;
        else if (b < 8'hFC)
            len = 3'd5;
        else if (b < 8'hFE)
            len = 3'd6;
        else
            len = 3'd1;
        return len;
    endfunction

endpackage

// ===== hw/rtl/lenient_utf8_to_utf32_decoder.sv =====
// Lenient UTF-8 to UTF-32 decoder: byte-at-a-time decode with a result run buffer.
//
// Takes one byte per item and returns code points of up to 31 bits, using
// lead lengths of 2 to 6 bytes. Malformed or truncated sequences come out as
// raw bytes with raw_fallback set. Each input byte is decoded in the cycle it
// is accepted, and all results it causes (zero to six) are loaded into a
// run buffer that drives the output one result per cycle while out_stall is
// low. A byte causing zero or one result does not hold the input, so one
// byte per cycle is sustained on well-formed text while the output does not
// stall; a byte causing k results holds the input until its run has drained
// one result per cycle through the single output. The next byte is accepted
// in the same cycle the last result of the previous run is taken.
module lenient_utf8_to_utf32_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_in,
    input  logic        end_of_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] code_point,
    output logic        raw_fallback,
    output logic        last_of_run,
    output logic        string_done
);

    // Decoder state
    utf8dec_pkg::byte_t lead_reg,      lead_next;
    utf8dec_pkg::len_t  rem_reg,       rem_next;
    utf8dec_pkg::len_t  held_cnt_reg,  held_cnt_next;
    utf8dec_pkg::cp_t   partial_reg,   partial_next;
    utf8dec_pkg::byte_t held_reg  [utf8dec_pkg::HELD_DEPTH];
    utf8dec_pkg::byte_t held_next [utf8dec_pkg::HELD_DEPTH];

    // Run buffer
    utf8dec_pkg::result_t run_reg  [utf8dec_pkg::RUN_DEPTH];
    utf8dec_pkg::result_t run_next [utf8dec_pkg::RUN_DEPTH];
    utf8dec_pkg::len_t    run_len_reg, run_len_next;
    utf8dec_pkg::len_t    run_idx_reg, run_idx_next;
    logic                 run_eos_reg, run_eos_next;

    // Decode terms
    utf8dec_pkg::len_t  in_len;
    utf8dec_pkg::len_t  rem_dec;
    utf8dec_pkg::len_t  n;
    utf8dec_pkg::cp_t   pv_shift;
    logic               pending;
    logic               is_cont;
    logic               consumed;
    logic               complete;
    logic               starts;
    logic               pend_after;
    logic               accept;
    logic               pop;
    logic               pop_last;

    // Handshake
    assign out_valid = (run_idx_reg != run_len_reg);
    assign pop       = out_valid && !out_stall;
    assign pop_last  = pop && ((run_idx_reg + 3'd1) == run_len_reg);
    assign in_stall  = out_valid && !pop_last;
    assign accept    = in_valid && !in_stall;

    // Output from the run buffer
    assign code_point   = run_reg[run_idx_reg].cp;
    assign raw_fallback = run_reg[run_idx_reg].raw;
    assign last_of_run  = ((run_idx_reg + 3'd1) == run_len_reg);
    assign string_done  = last_of_run && run_eos_reg;

    // Byte classification
    assign pending  = (rem_reg != 3'd0);
    assign is_cont  = (byte_in[7:6] == utf8dec_pkg::CONT_TAG);
    assign consumed = pending && is_cont;
    assign rem_dec  = rem_reg - 3'd1;
    assign complete = consumed && (rem_dec == 3'd0);
    assign pv_shift = {partial_reg[utf8dec_pkg::CP_WIDTH-7:0], byte_in[5:0]};
    assign in_len   = utf8dec_pkg::seq_length(byte_in);
    assign starts   = !consumed && (in_len > 3'd1)
                      && (in_len <= 3'(utf8dec_pkg::MAX_SEQ_BYTES));
    assign pend_after = starts || (consumed && !complete);

    // Result list and next state for one byte
    always_comb
    begin
        n = 3'd0;
        for (int i = 0; i < utf8dec_pkg::RUN_DEPTH; i++)
        begin
            run_next[i] = run_reg[i];
        end
        for (int i = 0; i < utf8dec_pkg::HELD_DEPTH; i++)
        begin
            held_next[i] = held_reg[i];
        end
        lead_next     = lead_reg;
        rem_next      = rem_reg;
        held_cnt_next = held_cnt_reg;
        partial_next  = partial_reg;
        run_len_next  = run_len_reg;
        run_idx_next  = run_idx_reg;
        run_eos_next  = run_eos_reg;

        // Drain
        if (pop_last)
        begin
            run_len_next = 3'd0;
            run_idx_next = 3'd0;
        end
        else if (pop)
        begin
            run_idx_next = run_idx_reg + 3'd1;
        end

        if (accept)
        begin
            // Pending sequence broken by a non-continuation byte
            if (pending && !is_cont)
            begin
                run_next[n] = '{cp: utf8dec_pkg::cp_t'(lead_reg), raw: 1'b1};
                n = n + 3'd1;
                for (int i = 0; i < utf8dec_pkg::HELD_DEPTH; i++)
                begin
                    if (3'(i) < held_cnt_reg)
                    begin
                        run_next[n] = '{cp: utf8dec_pkg::cp_t'(held_reg[i]), raw: 1'b1};
                        n = n + 3'd1;
                    end
                end
                rem_next      = 3'd0;
                held_cnt_next = 3'd0;
                partial_next  = '0;
            end

            // Continuation byte
            if (consumed)
            begin
                rem_next = rem_dec;
                if (complete)
                begin
                    run_next[n] = '{cp: pv_shift, raw: 1'b0};
                    n = n + 3'd1;
                    held_cnt_next = 3'd0;
                    partial_next  = '0;
                end
                else
                begin
                    partial_next = pv_shift;
                    if (held_cnt_reg < 3'(utf8dec_pkg::HELD_DEPTH))
                    begin
                        held_next[held_cnt_reg[1:0]] = byte_in;
                        held_cnt_next = held_cnt_reg + 3'd1;
                    end
                end
            end
            else if (starts)
            begin
                // New lead byte
                lead_next     = byte_in;
                partial_next  = utf8dec_pkg::cp_t'(byte_in
                                & (utf8dec_pkg::LEAD_BITS >> in_len));
                rem_next      = in_len - 3'd1;
                held_cnt_next = 3'd0;
            end
            else
            begin
                // Single byte, passed as its own value
                run_next[n] = '{cp: utf8dec_pkg::cp_t'(byte_in), raw: 1'b0};
                n = n + 3'd1;
            end

            // End of string flushes what is still pending
            if (end_of_string && pend_after)
            begin
                if (starts)
                begin
                    run_next[n] = '{cp: utf8dec_pkg::cp_t'(byte_in), raw: 1'b1};
                    n = n + 3'd1;
                end
                else
                begin
                    run_next[n] = '{cp: utf8dec_pkg::cp_t'(lead_reg), raw: 1'b1};
                    n = n + 3'd1;
                    for (int i = 0; i < utf8dec_pkg::HELD_DEPTH; i++)
                    begin
                        if (3'(i) < held_cnt_reg)
                        begin
                            run_next[n] = '{cp: utf8dec_pkg::cp_t'(held_reg[i]),
                                            raw: 1'b1};
                            n = n + 3'd1;
                        end
                    end
                    if (held_cnt_reg < 3'(utf8dec_pkg::HELD_DEPTH))
                    begin
                        run_next[n] = '{cp: utf8dec_pkg::cp_t'(byte_in), raw: 1'b1};
                        n = n + 3'd1;
                    end
                end
                rem_next      = 3'd0;
                held_cnt_next = 3'd0;
                partial_next  = '0;
            end

            run_len_next = n;
            run_idx_next = 3'd0;
            run_eos_next = end_of_string;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg     <= '0;
            rem_reg      <= '0;
            held_cnt_reg <= '0;
            partial_reg  <= '0;
            run_len_reg  <= '0;
            run_idx_reg  <= '0;
            run_eos_reg  <= 1'b0;
        end
        else
        begin
            lead_reg     <= lead_next;
            rem_reg      <= rem_next;
            held_cnt_reg <= held_cnt_next;
            partial_reg  <= partial_next;
            run_len_reg  <= run_len_next;
            run_idx_reg  <= run_idx_next;
            run_eos_reg  <= run_eos_next;
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < utf8dec_pkg::RUN_DEPTH; i++)
        begin
            run_reg[i] <= run_next[i];
        end
        for (int i = 0; i < utf8dec_pkg::HELD_DEPTH; i++)
        begin
            held_reg[i] <= held_next[i];
        end
    end

    // Read pointer stays within the loaded run
    assert property (@(posedge clk) disable iff (!rst_n)
        run_idx_reg <= run_len_reg)
        else $error("run read index past run length");

    // Held bytes only exist inside a pending sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == 3'd0) |-> (held_cnt_reg == 3'd0))
        else $error("held bytes with no pending sequence");

    // End of string always leaves no sequence pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_string) |=> (rem_reg == 3'd0))
        else $error("sequence still pending after end of string");

    // End of string always produces at least one result
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_string) |=> out_valid)
        else $error("end of string gave no result");

    // Held count never exceeds its store
    assert property (@(posedge clk) disable iff (!rst_n)
        held_cnt_reg <= 3'(utf8dec_pkg::HELD_DEPTH))
        else $error("held count overflow");

endmodule
